// ===== rtl/hsvt_pkg.sv =====
// Shared types and codes for the hashed symbol value table.
package hsvt_pkg;

  localparam int NAME_W  = 64;
  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 16;

  // Multiplier of the name hash
  localparam int HASH_MULT = 37;

  // Request actions
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOT_FOUND = 3'd1;
  localparam logic [2:0] STS_FULL      = 3'd2;
  localparam logic [2:0] STS_PRESENT   = 3'd3;
  localparam logic [2:0] STS_EMPTY     = 3'd4;

  // One table slot as held in the slot memory
  typedef struct packed {
    logic               used;
    logic [NAME_W-1:0]  name;
    logic [VALUE_W-1:0] value;
  } slot_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLEAR = 9'b000000010,
    ST_HASH  = 9'b000000100,
    ST_HMUL  = 9'b000001000,
    ST_HRED  = 9'b000010000,
    ST_HQS   = 9'b000100000,
    ST_HCOR  = 9'b001000000,
    ST_SCAN  = 9'b010000000,
    ST_PROBE = 9'b100000000
  } state_t;

endpackage

// ===== rtl/hashed_symbol_value_table.sv =====
// Top level: hashed name-to-value table with a sequenced slot memory.
//
// Requests are taken when start is high and busy is low; busy stays high until
// the cycle in which the single result is shown on the out_ ports with out_valid,
// and the receiver must take it then (a new request may be taken in that same
// cycle). Names are hashed one character at a time through one shared
// multiplier (per character: check for the end, multiply by 37, reciprocal
// multiply, back-multiply, correct), and a last check ends the name. Lookups
// then walk the slot memory one slot per cycle through its single read port, and
// an insert of a new name then probes linearly from the hash for a free slot.
// Clear all sweeps the whole memory; the same sweep runs after reset, during
// which busy is high and no request is taken. Actions 5 to 7 give their result
// in the next cycle without raising busy.
module hashed_symbol_value_table import hsvt_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int MAX_NAME_CHARS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [63:0]        in_name_chars,
  input  logic [3:0]         in_name_length,
  input  logic signed [15:0] in_value_in,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_value_out,
  output logic [5:0]         out_slot_index,
  output logic [6:0]         out_entry_count
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C   = CW'(TABLE_SLOTS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
  localparam logic [15:0]   SLOTS_16  = 16'(TABLE_SLOTS);
  localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
  localparam logic [3:0]    MAXC      = 4'(MAX_NAME_CHARS);

  // Control and working registers
  state_t              state_r, state_nxt;
  logic [2:0]          act_r, act_nxt;
  logic [NAME_W-1:0]   name_r, name_nxt;
  logic [NAME_W-1:0]   sh_r, sh_nxt;
  logic [3:0]          lim_r, lim_nxt;
  logic [3:0]          n_r, n_nxt;
  logic [VALUE_W-1:0]  vin_r, vin_nxt;
  logic [SW-1:0]       h_r, h_nxt;
  logic [15:0]         x_r, x_nxt;
  logic [47:0]         prod_r, prod_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [SW-1:0]       pa_r, pa_nxt;
  logic                rv_r, rv_nxt;
  logic [SW-1:0]       ri_r, ri_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic                ov_r, ov_nxt;
  logic [2:0]          os_r, os_nxt;
  logic [VALUE_W-1:0]  ovo_r, ovo_nxt;
  logic [SW-1:0]       oidx_r, oidx_nxt;

  // Slot memory
  slot_t               mem_r [TABLE_SLOTS];
  slot_t               rdata_r;
  logic                we;
  logic [SW-1:0]       waddr;
  slot_t               wdata;
  logic [SW-1:0]       raddr;

  // Shared multiplier
  logic [15:0]         mul_a;
  logic [31:0]         mul_b;

  logic [NAME_W-1:0]   key;
  logic [CHAR_W-1:0]   cur_ch;
  logic [15:0]         x_sum;
  logic [15:0]         rem;
  logic                hit;
  logic [CW-1:0]       len_ext;

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_value_out   = ovo_r;
  assign out_slot_index  = 6'(oidx_r);
  assign out_entry_count = 7'(cnt_r);

  // Key: the hashed characters left-aligned, the rest zero
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      key[NAME_W-1-CHAR_W*j -: CHAR_W] =
        (4'(j) < n_r) ? name_r[NAME_W-1-CHAR_W*j -: CHAR_W] : '0;
    end
  end

  assign cur_ch  = sh_r[NAME_W-1 -: CHAR_W];
  assign x_sum   = prod_r[15:0] + {8'd0, cur_ch};
  assign rem     = x_r - prod_r[15:0];
  assign hit     = rv_r && rdata_r.used && (rdata_r.name == key);
  assign len_ext = '0;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_HMUL: begin
        mul_a = 16'(h_r);
        mul_b = 32'(HASH_MULT);
      end
      ST_HRED: begin
        mul_a = x_sum;
        mul_b = RECIP;
      end
      ST_HQS: begin
        mul_a = prod_r[47:32];
        mul_b = 32'(TABLE_SLOTS);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    name_nxt     = name_r;
    sh_nxt       = sh_r;
    lim_nxt      = lim_r;
    n_nxt        = n_r;
    vin_nxt      = vin_r;
    h_nxt        = h_r;
    x_nxt        = x_r;
    prod_nxt     = prod_r;
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    pa_nxt       = pa_r;
    rv_nxt       = 1'b0;
    ri_nxt       = ri_r;
    clr_resp_nxt = clr_resp_r;
    ov_nxt       = 1'b0;
    os_nxt       = os_r;
    ovo_nxt      = ovo_r;
    oidx_nxt     = oidx_r;
    we           = 1'b0;
    waddr        = ri_r;
    wdata        = '0;
    raddr        = ptr_r[SW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          name_nxt = in_name_chars;
          sh_nxt   = in_name_chars;
          lim_nxt  = (in_name_length > MAXC) ? MAXC : in_name_length;
          vin_nxt  = in_value_in;
          n_nxt    = '0;
          h_nxt    = '0;
          ptr_nxt  = '0;
          if (in_action == ACT_CLEAR) begin
            clr_resp_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end else if (in_action > ACT_CLEAR) begin
            // unknown action: report ok, change nothing
            ov_nxt   = 1'b1;
            os_nxt   = STS_OK;
            ovo_nxt  = '0;
            oidx_nxt = '0;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end

      // Empty every slot, one per cycle
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = ptr_r[SW-1:0];
        wdata   = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[SW-1:0] == LAST_SLOT) begin
          cnt_nxt      = len_ext;
          ov_nxt       = clr_resp_r;
          os_nxt       = STS_OK;
          ovo_nxt      = '0;
          oidx_nxt     = '0;
          clr_resp_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      // Next character or end of name
      ST_HASH: begin
        ptr_nxt = '0;
        if (n_r == lim_r || cur_ch == '0) begin
          if (n_r == '0) begin
            ov_nxt    = 1'b1;
            os_nxt    = STS_EMPTY;
            ovo_nxt   = '0;
            oidx_nxt  = '0;
            state_nxt = ST_IDLE;
          end else if (act_r == ACT_INSERT && cnt_r >= SLOTS_C) begin
            ov_nxt    = 1'b1;
            os_nxt    = STS_FULL;
            ovo_nxt   = '0;
            oidx_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else begin
          state_nxt = ST_HMUL;
        end
      end

      // h * 37
      ST_HMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_HRED;
      end

      // x = h*37 + c, then estimate x / slots by the reciprocal
      ST_HRED: begin
        x_nxt     = x_sum;
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_HQS;
      end

      // quotient estimate times slots
      ST_HQS: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_HCOR;
      end

      // remainder, estimate may be one short
      ST_HCOR: begin
        h_nxt     = (rem >= SLOTS_16) ? SW'(rem - SLOTS_16) : SW'(rem);
        n_nxt     = n_r + 1'b1;
        sh_nxt    = sh_r << CHAR_W;
        state_nxt = ST_HASH;
      end

      // Walk all slots for the key, read data registered, arriving in the cycle after its address
      ST_SCAN: begin
        raddr = ptr_r[SW-1:0];
        if (ptr_r != SLOTS_C) begin
          ptr_nxt = ptr_r + 1'b1;
          rv_nxt  = 1'b1;
          ri_nxt  = ptr_r[SW-1:0];
        end
        if (hit) begin
          ov_nxt    = 1'b1;
          os_nxt    = STS_OK;
          ovo_nxt   = '0;
          oidx_nxt  = ri_r;
          state_nxt = ST_IDLE;
          waddr     = ri_r;
          case (act_r)
            ACT_INSERT: begin
              os_nxt = STS_PRESENT;
            end
            ACT_DELETE: begin
              we         = 1'b1;
              wdata.used = 1'b0;
              wdata.name = rdata_r.name;
              cnt_nxt    = cnt_r - 1'b1;
            end
            ACT_READ: begin
              ovo_nxt = rdata_r.value;
            end
            ACT_WRITE: begin
              we          = 1'b1;
              wdata.used  = 1'b1;
              wdata.name  = rdata_r.name;
              wdata.value = vin_r;
            end
            default: begin
              os_nxt = STS_OK;
            end
          endcase
        end else if (!rv_r && ptr_r == SLOTS_C) begin
          if (act_r == ACT_INSERT) begin
            ptr_nxt   = '0;
            pa_nxt    = h_r;
            rv_nxt    = 1'b0;
            state_nxt = ST_PROBE;
          end else begin
            ov_nxt    = 1'b1;
            os_nxt    = STS_NOT_FOUND;
            ovo_nxt   = '0;
            oidx_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end

      // Linear probe from the hash for the first free slot
      ST_PROBE: begin
        raddr = pa_r;
        if (ptr_r != SLOTS_C) begin
          ptr_nxt = ptr_r + 1'b1;
          pa_nxt  = (pa_r == LAST_SLOT) ? '0 : pa_r + 1'b1;
          rv_nxt  = 1'b1;
          ri_nxt  = pa_r;
        end
        if (rv_r && !rdata_r.used) begin
          we          = 1'b1;
          waddr       = ri_r;
          wdata.used  = 1'b1;
          wdata.name  = key;
          wdata.value = vin_r;
          cnt_nxt     = cnt_r + 1'b1;
          ov_nxt      = 1'b1;
          os_nxt      = STS_OK;
          ovo_nxt     = '0;
          oidx_nxt    = ri_r;
          state_nxt   = ST_IDLE;
        end else if (!rv_r && ptr_r == SLOTS_C) begin
          ov_nxt    = 1'b1;
          os_nxt    = STS_FULL;
          ovo_nxt   = '0;
          oidx_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  // Control state, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      ptr_r      <= '0;
      cnt_r      <= '0;
      rv_r       <= 1'b0;
      clr_resp_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      cnt_r      <= cnt_nxt;
      rv_r       <= rv_nxt;
      clr_resp_r <= clr_resp_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    name_r <= name_nxt;
    sh_r   <= sh_nxt;
    lim_r  <= lim_nxt;
    n_r    <= n_nxt;
    vin_r  <= vin_nxt;
    h_r    <= h_nxt;
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    pa_r   <= pa_nxt;
    ri_r   <= ri_nxt;
    os_r   <= os_nxt;
    ovo_r  <= ovo_nxt;
    oidx_r <= oidx_nxt;
  end

endmodule
